// ===== design/mdfs_pkg.sv =====
package mdfs_pkg;

	localparam int MAX_VERTICES_DEFAULT = 32;
	localparam int VERTEX_W = 5;
	localparam int ROW_W = 32;
	localparam int COUNT_W = 6;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

	typedef struct packed {
		logic                mode;
		logic [VERTEX_W-1:0] row_index;
		logic [ROW_W-1:0]    row_bits;
		logic [VERTEX_W-1:0] start_vertex;
	} in_item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] visited_vertex;
		logic                last_in_run;
		logic                bad_start;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BAD,
		ST_SCAN,
		ST_POP
	} state_t;

	typedef struct packed {
		logic cfg_write;
		logic load_row;
		logic start_search;
		logic push;
		logic pop_step;
		logic pop_fetch;
		logic emit_last;
		logic emit_bad;
	} cmd_t;

	typedef struct packed {
		logic in_search;
		logic in_bad;
		logic found;
		logic depth_one;
		logic out_free;
	} status_t;

endpackage

// ===== design/matrix_depth_first_search_unit.sv =====
// A row load is taken while the controller is idle. A search keeps the input stalled until
// its final result is emitted: each push reads the next row from the found vertex directly,
// each pop reads the stack memory and then the row memory, one after the other, and a final
// scan emits the last result. A bad start passes through the bad-start state. The first
// result is registered in the output register after the scan of the start vertex's row.
// Output stalls hold a search or a bad start until the output register is free. Reset
// clears the controller, the stack depth, the visited marks and the output valid, and sets
// the vertex count to 32; the row and stack memories are not cleared.
module matrix_depth_first_search_unit #(
	parameter int MAX_VERTICES = mdfs_pkg::MAX_VERTICES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mdfs_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mdfs_pkg::out_item_t          out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mdfs_pkg::COUNT_W-1:0] cfg_data
);
	import mdfs_pkg::*;

	cmd_t    cmd;
	status_t status;

	mdfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mdfs_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (in_item),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== design/mdfs_ram.sv =====
module mdfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mdfs_ctrl.sv =====
module mdfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  mdfs_pkg::status_t status,
	output mdfs_pkg::cmd_t    cmd
);
	import mdfs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && status.in_search) begin
					state_d = status.in_bad ? ST_BAD : ST_SCAN;
				end
			end
			ST_BAD: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!status.found) begin
					if (status.depth_one) begin
						if (status.out_free) begin
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				state_d = ST_SCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cfg_write = cfg_valid;
				if (in_valid) begin
					cmd.start_search = status.in_search;
					cmd.load_row = !status.in_search;
				end
			end
			ST_BAD: begin
				cmd.emit_bad = status.out_free;
			end
			ST_SCAN: begin
				if (status.found) begin
					cmd.push = status.out_free;
				end else if (status.depth_one) begin
					cmd.emit_last = status.out_free;
				end else begin
					cmd.pop_step = 1'b1;
				end
			end
			ST_POP: begin
				cmd.pop_fetch = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

endmodule

// ===== design/mdfs_datapath.sv =====
module mdfs_datapath #(
	parameter int MAX_VERTICES = mdfs_pkg::MAX_VERTICES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mdfs_pkg::cmd_t                cmd,
	output mdfs_pkg::status_t             status,
	input  mdfs_pkg::in_item_t            in_item,
	input  logic [mdfs_pkg::COUNT_W-1:0]  cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mdfs_pkg::out_item_t           out_item
);
	import mdfs_pkg::*;

	localparam int AddrW = $clog2(MAX_VERTICES);
	localparam int DepthW = $clog2(MAX_VERTICES + 1);
	localparam int Cap = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

	logic [COUNT_W-1:0]  vcount_q;
	logic [ROW_W-1:0]    visited_q;
	logic [DepthW-1:0]   depth_q;
	logic [VERTEX_W-1:0] pend_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [COUNT_W-1:0]  lim;
	logic [ROW_W-1:0]    lim_mask;
	logic [ROW_W-1:0]    row_rdata;
	logic [ROW_W-1:0]    cand;
	logic [VERTEX_W-1:0] found_v;
	logic [VERTEX_W-1:0] stack_rdata;
	logic [DepthW-1:0]   top_after_pop;
	logic                out_free;

	logic                row_we;
	logic                row_re;
	logic [AddrW-1:0]    row_raddr;
	logic                stk_we;
	logic [AddrW-1:0]    stk_waddr;
	logic [VERTEX_W-1:0] stk_wdata;

	assign lim = (vcount_q > COUNT_W'(Cap)) ? COUNT_W'(Cap) : vcount_q;

	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			lim_mask[j] = (COUNT_W'(j) < lim);
		end
	end

	assign cand = row_rdata & ~visited_q & lim_mask;

	always_comb begin
		found_v = '0;
		for (int j = ROW_W - 1; j >= 0; j--) begin
			if (cand[j]) begin
				found_v = VERTEX_W'(j);
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign top_after_pop = depth_q - DepthW'(2);

	assign status.in_search = in_item.mode;
	assign status.in_bad = ({1'b0, in_item.start_vertex} >= lim);
	assign status.found = |cand;
	assign status.depth_one = (depth_q == DepthW'(1));
	assign status.out_free = out_free;

	assign row_we = cmd.load_row && (32'(in_item.row_index) < 32'(MAX_VERTICES));
	assign row_re = cmd.start_search || cmd.push || cmd.pop_fetch;

	always_comb begin
		row_raddr = AddrW'(in_item.start_vertex);
		if (cmd.push) begin
			row_raddr = AddrW'(found_v);
		end else if (cmd.pop_fetch) begin
			row_raddr = AddrW'(stack_rdata);
		end
	end

	always_comb begin
		stk_we = cmd.start_search || cmd.push;
		stk_waddr = '0;
		stk_wdata = in_item.start_vertex;
		if (cmd.push) begin
			stk_waddr = depth_q[AddrW-1:0];
			stk_wdata = found_v;
		end
	end

	mdfs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_VERTICES)
	) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (AddrW'(in_item.row_index)),
		.wdata (in_item.row_bits),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	mdfs_ram #(
		.WIDTH(VERTEX_W),
		.DEPTH(MAX_VERTICES)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (cmd.pop_step),
		.raddr (top_after_pop[AddrW-1:0]),
		.rdata (stack_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= COUNT_RESET;
			visited_q <= '0;
			depth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_write) begin
				vcount_q <= cfg_data;
			end
			if (cmd.start_search) begin
				visited_q <= status.in_bad ? '0 : (ROW_W'(1) << in_item.start_vertex);
				depth_q <= status.in_bad ? '0 : DepthW'(1);
			end else if (cmd.push) begin
				visited_q <= visited_q | (ROW_W'(1) << found_v);
				depth_q <= depth_q + DepthW'(1);
			end else if (cmd.pop_step || cmd.emit_last) begin
				depth_q <= depth_q - DepthW'(1);
			end
			if (cmd.push || cmd.emit_last || cmd.emit_bad) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_search) begin
			pend_q <= in_item.start_vertex;
		end else if (cmd.push) begin
			pend_q <= found_v;
		end
		if (cmd.push) begin
			out_q <= '{visited_vertex: pend_q, last_in_run: 1'b0, bad_start: 1'b0};
		end else if (cmd.emit_last) begin
			out_q <= '{visited_vertex: pend_q, last_in_run: 1'b1, bad_start: 1'b0};
		end else if (cmd.emit_bad) begin
			out_q <= '{visited_vertex: '0, last_in_run: 1'b1, bad_start: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

`ifndef ASSERT_OFF
	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.emit_last || cmd.emit_bad) |-> out_free)
		else $error("Result produced while the output register is occupied.");

	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (depth_q < DepthW'(MAX_VERTICES)))
		else $error("Stack push beyond the stack depth.");

	a_pop_has_parent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_step |-> (depth_q >= DepthW'(2)))
		else $error("Stack pop without a parent entry.");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_last |=> (depth_q == '0))
		else $error("Stack not empty after the final result.");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import mdfs_pkg::*;

	localparam int MAX_VERTICES = MAX_VERTICES_DEFAULT;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 9;

	typedef struct packed {
		logic [5:0]          resume;
		logic [VERTEX_W-1:0] vertex;
	} walk_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	in_item_t pending_items[$];
	out_item_t expected_visits[$];
	logic [ROW_W-1:0] graph_rows[MAX_VERTICES];
	logic [COUNT_W-1:0] vertex_limit = COUNT_RESET;
	logic [ROW_W-1:0] reached_mask;
	walk_entry_t walk_frames[MAX_VERTICES];
	int walk_depth;

	logic steady_flow = 1'b0;
	int send_gap;
	int stall_left;
	int hold_ask = 0;
	int hold_seen;
	int stuck_cycles = 0;
	int mismatches = 0;
	int loads_taken = 0;
	int searches_taken = 0;
	int results_taken = 0;
	int bad_results = 0;
	int count_writes = 0;

	matrix_depth_first_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic out_item_t make_visit(int v, logic last, logic bad);
		out_item_t o;
		o.visited_vertex = v[VERTEX_W-1:0];
		o.last_in_run = last;
		o.bad_start = bad;
		return o;
	endfunction

	function automatic void predict_walk(logic [VERTEX_W-1:0] start);
		int n;
		int lim;
		int r;
		int emitted;
		walk_entry_t top;
		logic [ROW_W-1:0] row;
		out_item_t tail;
		n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
		lim = (n < ROW_W) ? n : ROW_W;
		reached_mask = '0;
		walk_depth = 0;
		if (start >= n) begin
			expected_visits.push_back(make_visit(0, 1'b1, 1'b1));
			return;
		end
		reached_mask[start] = 1'b1;
		walk_frames[0] = {6'd0, start};
		walk_depth = 1;
		expected_visits.push_back(make_visit(start, 1'b0, 1'b0));
		emitted = 1;
		while (walk_depth > 0) begin
			top = walk_frames[walk_depth - 1];
			row = graph_rows[top.vertex];
			r = top.resume;
			while (r < lim && !(row[r] && !reached_mask[r]))
				r++;
			if (r < lim && walk_depth < MAX_VERTICES && emitted < 32) begin
				walk_frames[walk_depth - 1] = {6'(r + 1), top.vertex};
				walk_frames[walk_depth] = {6'd0, 5'(r)};
				walk_depth++;
				reached_mask[r] = 1'b1;
				expected_visits.push_back(make_visit(r, 1'b0, 1'b0));
				emitted++;
			end else
				walk_depth--;
		end
		tail = expected_visits.pop_back();
		tail.last_in_run = 1'b1;
		expected_visits.push_back(tail);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_flow || roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t make_load(int idx, logic [ROW_W-1:0] bits);
		in_item_t it;
		it.mode = MODE_LOAD;
		it.row_index = idx[VERTEX_W-1:0];
		it.row_bits = bits;
		it.start_vertex = VERTEX_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_search(int start);
		in_item_t it;
		it.mode = MODE_SEARCH;
		it.row_index = VERTEX_W'($urandom);
		it.row_bits = $urandom;
		it.start_vertex = start[VERTEX_W-1:0];
		return it;
	endfunction

	function automatic logic [ROW_W-1:0] random_row(int idx);
		case ($urandom_range(0, 6))
			0: return $urandom & $urandom & $urandom;
			1: return $urandom & $urandom;
			2: return $urandom;
			3: return 32'h1 << $urandom_range(0, ROW_W - 1);
			4: return '0;
			5: return '1;
			default: return (32'h1 << ((idx + 1) % ROW_W)) | (32'h1 << $urandom_range(0, ROW_W - 1));
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] phase_count(int p);
		case (p)
			0: return 6'd1;
			1: return 6'd0;
			2: return 6'd63;
			3: return 6'd2;
			4: return 6'd17;
			5: return 6'd40;
			6: return 6'd31;
			7: return 6'd8;
			default: return 6'd32;
		endcase
	endfunction

	task automatic queue_random_items(int count, int n);
		int idx;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 40) begin
				idx = $urandom_range(0, MAX_VERTICES - 1);
				pending_items.push_back(make_load(idx, random_row(idx)));
			end else if (n > 0 && $urandom_range(0, 9) != 0)
				pending_items.push_back(make_search($urandom_range(0, n - 1)));
			else
				pending_items.push_back(make_search($urandom_range(0, MAX_VERTICES - 1)));
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_visits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(logic [COUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_items.size() != 0) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
				send_gap <= pick_gap();
			end else
				in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			out_stall <= 1'b1;
			stall_left <= HOLD_CYCLES;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
			out_stall <= 1'b1;
			stall_left <= pick_gap();
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			vertex_limit = cfg_data;
			count_writes++;
		end
		if (arst_n && in_valid && !in_stall) begin
			if (in_item.mode == MODE_LOAD) begin
				graph_rows[in_item.row_index] = in_item.row_bits;
				loads_taken++;
			end else begin
				predict_walk(in_item.start_vertex);
				searches_taken++;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_taken++;
			if (out_item.bad_start)
				bad_results++;
			if (expected_visits.size() == 0) begin
				$error("result with no expected transaction: vertex %0d last %0d bad %0d",
					out_item.visited_vertex, out_item.last_in_run, out_item.bad_start);
				mismatches++;
			end else begin
				want = expected_visits.pop_front();
				check_field("visited_vertex", want.visited_vertex, out_item.visited_vertex);
				check_field("last_in_run", want.last_in_run, out_item.last_in_run);
				check_field("bad_start", want.bad_start, out_item.bad_start);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("matrix_depth_first_search_unit verification failed");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		int n;
		logic [COUNT_W-1:0] setting;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Every row is loaded before the first search, as a chain with self loops.
		for (int i = 0; i < MAX_VERTICES; i++)
			pending_items.push_back(make_load(i, (i < MAX_VERTICES - 1) ?
				((32'h1 << i) | (32'h1 << (i + 1))) : 32'h8000_0001));
		pending_items.push_back(make_search(0));
		pending_items.push_back(make_search(31));
		pending_items.push_back(make_load(5, 32'h0));
		pending_items.push_back(make_search(5));
		pending_items.push_back(make_search(4));
		pending_items.push_back(make_load(0, 32'hFFFF_FFFF));
		pending_items.push_back(make_search(0));
		pending_items.push_back(make_load(10, 32'hAAAA_AAAA));
		pending_items.push_back(make_search(10));
		pending_items.push_back(make_search(20));
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			setting = phase_count(p);
			n = (setting > MAX_VERTICES) ? MAX_VERTICES : setting;
			steady_flow <= (p % 3 == 2);
			write_vertex_count(setting);
			if (n > 0)
				pending_items.push_back(make_search(n - 1));
			if (n < MAX_VERTICES)
				pending_items.push_back(make_search(n));
			queue_random_items((p == PHASES - 1) ? 60 : 45, n);
			// In the last phase the output side holds off while the input side keeps offering items.
			if (p == PHASES - 1)
				hold_ask <= hold_ask + 1;
			wait_idle();
		end

		$display("Covered %0d row loads and %0d searches under %0d vertex count settings,",
			loads_taken, searches_taken, count_writes);
		$display("checking %0d visited vertices of which %0d flagged a bad start.",
			results_taken, bad_results);
		if (mismatches == 0)
			$display("matrix_depth_first_search_unit verification clean");
		else
			$display("matrix_depth_first_search_unit verification failed");
		$finish;
	end

endmodule
